// ----- sv/swlf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear fit package
// Shared constants and widths for the window fit block and its RAM.
// ----------------------------------------------------------------------------
package swlf_pkg;
    localparam int Window     = 32;
    localparam int SampleBits = 16;
    localparam int FracBits   = 16;
    localparam int SlotBits   = $clog2(Window);
    localparam int SumBits    = SampleBits + SlotBits;
    localparam int SqBits     = 2 * SampleBits + SlotBits;
    localparam int ProdBits   = SumBits + SqBits;
    localparam int NumBits    = ProdBits + 1 + FracBits;
    localparam int QuotBits   = NumBits;
    localparam int DivSteps   = NumBits;
    localparam int OutBits    = 48;
    localparam int DataBits   = 32;
endpackage

// ----- sv/sliding_window_linear_fit.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear fit
// Least-squares slope and intercept over the last Window samples.
// ----------------------------------------------------------------------------
// After reset the block sweeps every slot of its sample RAM to zero
// before it takes the first word. It takes no new word until it has
// loaded the last result into its output register. The restoring divider
// retires one quotient bit a cycle, once for the slope and once for the
// intercept. A single SumBits x SqBits multiplier (21x37) forms the six
// products in turn. A degenerate window skips the divider. A new word is
// taken while the previous result still waits on the output.
module sliding_window_linear_fit
    import swlf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // new_x[15:0], new_y[31:16]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [95:0]         m_tdata,   // slope[47:0], intercept[95:48]
    output logic                m_tuser    // degenerate
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_UPD, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_DEN, S_DIV, S_STORE
    } state_t;

    state_t                       state_reg;
    logic [SlotBits-1:0]          slot_reg;
    logic [SampleBits-1:0]        nx_reg, ny_reg;
    logic [SumBits-1:0]           tx_reg, ty_reg;
    logic [SqBits-1:0]            txx_reg, txy_reg;
    logic [ProdBits:0]            p_reg, den_reg;
    logic [ProdBits:0]            prod_reg;
    logic [ProdBits:0]            ps_reg, ms_reg, pi_reg;
    logic                         second_reg;
    logic [NumBits-1:0]           num_reg;
    logic [NumBits-1:0]           rem_reg;
    logic [QuotBits-1:0]          quo_reg;
    logic                         neg_reg;
    logic [$clog2(DivSteps+1)-1:0] cnt_reg;
    logic [OutBits-1:0]           slope_reg;
    logic                         out_valid_reg;
    logic [OutBits-1:0]           o_slope_reg, o_icpt_reg;
    logic                         o_deg_reg;

    logic                         ram_we;
    logic [DataBits-1:0]          ram_wdata, ram_rdata;
    logic [SampleBits-1:0]        ox, oy;
    logic                         load_out;

    assign ox = ram_rdata[SampleBits-1:0];
    assign oy = ram_rdata[DataBits-1:SampleBits];
    assign ram_we = (state_reg == S_CLEAR) || (state_reg == S_UPD);
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : {ny_reg, nx_reg};

    swlf_ram #(.WIDTH(DataBits), .DEPTH(Window)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // One shared multiplier, operands selected by state.
    logic [SumBits-1:0] mul_a;
    logic [SqBits-1:0]  mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M1: begin mul_a = SumBits'(Window); mul_b = txx_reg; end
            S_M2: begin mul_a = tx_reg; mul_b = SqBits'(tx_reg); end
            S_M3: begin mul_a = SumBits'(Window); mul_b = txy_reg; end
            S_M4: begin mul_a = tx_reg; mul_b = SqBits'(ty_reg); end
            S_M5: begin mul_a = ty_reg; mul_b = txx_reg; end
            S_M6: begin mul_a = tx_reg; mul_b = txy_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    logic [ProdBits-1:0] mul_full;
    assign mul_full = mul_a * mul_b;

    logic [NumBits:0] rem_try;
    logic [NumBits-1:0] rem_sh;
    assign rem_sh  = {rem_reg[NumBits-2:0], num_reg[NumBits-1]};
    assign rem_try = {1'b0, rem_sh} - {{(NumBits-ProdBits){1'b0}}, den_reg};

    logic [OutBits-1:0] sat_val;
    localparam logic [QuotBits-1:0] PosMax = QuotBits'((64'd1 << (OutBits-1)) - 1);
    localparam logic [QuotBits-1:0] NegMax = QuotBits'(64'd1 << (OutBits-1));
    always_comb begin
        if (neg_reg) begin
            sat_val = (quo_reg > NegMax) ? OutBits'(NegMax)
                                         : OutBits'(~quo_reg + 1'b1);
        end else begin
            sat_val = (quo_reg > PosMax) ? OutBits'(PosMax) : OutBits'(quo_reg);
        end
    end

    assign load_out = ((state_reg == S_DEN && p_reg <= prod_reg) ||
                       (state_reg == S_STORE && second_reg)) &&
                      (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {o_icpt_reg, o_slope_reg};
    assign m_tuser  = o_deg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            slot_reg      <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            txx_reg       <= '0;
            txy_reg       <= '0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    slot_reg <= slot_reg + 1'b1;
                    if (slot_reg == SlotBits'(Window - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        nx_reg    <= s_tdata[15:0];
                        ny_reg    <= s_tdata[31:16];
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_UPD;
                S_UPD: begin
                    tx_reg  <= tx_reg + SumBits'(nx_reg) - SumBits'(ox);
                    ty_reg  <= ty_reg + SumBits'(ny_reg) - SumBits'(oy);
                    txx_reg <= txx_reg + SqBits'(nx_reg * nx_reg) - SqBits'(ox * ox);
                    txy_reg <= txy_reg + SqBits'(nx_reg * ny_reg) - SqBits'(ox * oy);
                    slot_reg <= (slot_reg == SlotBits'(Window - 1)) ? '0 : slot_reg + 1'b1;
                    state_reg <= S_M1;
                end
                S_M1: begin p_reg <= (ProdBits+1)'(mul_full); state_reg <= S_M2; end
                S_M2: begin prod_reg <= (ProdBits+1)'(mul_full); state_reg <= S_DEN; end
                S_DEN: begin
                    if (p_reg <= prod_reg) begin
                        if (!out_valid_reg || m_tready) begin
                            o_slope_reg   <= '0;
                            o_icpt_reg    <= '0;
                            o_deg_reg     <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end else begin
                        den_reg   <= p_reg - prod_reg;
                        state_reg <= S_M3;
                    end
                end
                S_M3: begin ps_reg <= (ProdBits+1)'(mul_full); state_reg <= S_M4; end
                S_M4: begin ms_reg <= (ProdBits+1)'(mul_full); state_reg <= S_M5; end
                S_M5: begin pi_reg <= (ProdBits+1)'(mul_full); state_reg <= S_M6; end
                S_M6: begin
                    // Intercept terms wait in pi_reg/prod_reg; slope runs first.
                    prod_reg   <= (ProdBits+1)'(mul_full);
                    neg_reg    <= ps_reg < ms_reg;
                    num_reg    <= (ps_reg >= ms_reg)
                        ? NumBits'({ps_reg - ms_reg, {FracBits{1'b0}}})
                        : NumBits'({ms_reg - ps_reg, {FracBits{1'b0}}});
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    cnt_reg    <= '0;
                    second_reg <= 1'b0;
                    state_reg  <= S_DIV;
                end
                S_DIV: begin
                    num_reg <= {num_reg[NumBits-2:0], 1'b0};
                    if (!rem_try[NumBits]) begin
                        rem_reg <= rem_try[NumBits-1:0];
                        quo_reg <= {quo_reg[QuotBits-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[QuotBits-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ($clog2(DivSteps+1))'(DivSteps - 1)) begin
                        state_reg <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (!second_reg) begin
                        slope_reg  <= sat_val;
                        neg_reg    <= pi_reg < prod_reg;
                        num_reg    <= (pi_reg >= prod_reg)
                            ? NumBits'({pi_reg - prod_reg, {FracBits{1'b0}}})
                            : NumBits'({prod_reg - pi_reg, {FracBits{1'b0}}});
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                        cnt_reg    <= '0;
                        second_reg <= 1'b1;
                        state_reg  <= S_DIV;
                    end else if (!out_valid_reg || m_tready) begin
                        o_slope_reg   <= slope_reg;
                        o_icpt_reg    <= sat_val;
                        o_deg_reg     <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && s_tvalid) |=> state_reg == S_READ)
        else $error("accepted word did not start a read");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("word accepted during clearing sweep");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (o_slope_reg == '0 && o_icpt_reg == '0))
        else $error("degenerate result carries nonzero fit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("division with zero denominator");
endmodule

// ----- sv/swlf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module swlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear fit testbench
// Drives (x, y) sample words with random gaps, models the window sums and the
// fixed-point least-squares fit, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import swlf_pkg::*;

    localparam int RandomWords = 1800;
    localparam int MaxShown    = 10;

    typedef struct packed {
        logic [47:0] slope;
        logic [47:0] intercept;
        logic        degenerate;
    } fit_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        known;
        fit_t        fit;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;

    fit_t        fit_queue[$];
    logic [15:0] x_ring[Window];
    logic [15:0] y_ring[Window];
    int          ring_slot;
    logic [255:0] sum_x, sum_y, sum_xx, sum_xy;
    int          error_count;
    int          words_sent;
    bit          sending_done;
    bit          hold_off;
    row_t        rows[$];

    sliding_window_linear_fit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [47:0] fixed_quotient(logic [255:0] p, logic [255:0] m,
                                                   logic [255:0] den);
        logic [255:0] num;
        logic [255:0] q;
        logic         neg;
        neg = p < m;
        num = neg ? m - p : p - m;
        q = (num << FracBits) / den;
        if (neg) begin
            if (q > 256'h8000_0000_0000) q = 256'h8000_0000_0000;
            return 48'(-q);
        end
        if (q > 256'h7FFF_FFFF_FFFF) q = 256'h7FFF_FFFF_FFFF;
        return q[47:0];
    endfunction

    function automatic fit_t fit_next(logic [15:0] nx, logic [15:0] ny);
        fit_t         r;
        logic [255:0] ox, oy, n, den;
        ox = x_ring[ring_slot];
        oy = y_ring[ring_slot];
        x_ring[ring_slot] = nx;
        y_ring[ring_slot] = ny;
        ring_slot = (ring_slot + 1) % Window;
        sum_x  = sum_x + nx - ox;
        sum_y  = sum_y + ny - oy;
        sum_xx = sum_xx + 256'(nx) * nx - ox * ox;
        sum_xy = sum_xy + 256'(nx) * ny - ox * oy;
        n = Window;
        r = '0;
        if (n * sum_xx <= sum_x * sum_x) begin
            r.degenerate = 1'b1;
            return r;
        end
        den = n * sum_xx - sum_x * sum_x;
        r.slope = fixed_quotient(n * sum_xy, sum_x * sum_y, den);
        r.intercept = fixed_quotient(sum_xx * sum_y, sum_x * sum_xy, den);
        return r;
    endfunction

    task automatic add_row(logic [15:0] x, logic [15:0] y, logic known, fit_t fit);
        row_t r;
        r.x = x;
        r.y = y;
        r.known = known;
        r.fit = fit;
        rows.push_back(r);
    endtask

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic send_word(logic [15:0] x, logic [15:0] y);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_row(row_t r);
        fit_t expected_fit;
        expected_fit = fit_next(r.x, r.y);
        fit_queue.push_back(r.known ? r.fit : expected_fit);
        send_word(r.x, r.y);
    endtask

    initial begin
        fit_t zero_fit, degenerate_fit;
        row_t r;
        logic [15:0] base_x;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        ring_slot = 0;
        sum_x = '0; sum_y = '0; sum_xx = '0; sum_xy = '0;
        for (int i = 0; i < Window; i++) begin
            x_ring[i] = '0;
            y_ring[i] = '0;
        end
        zero_fit = '0;
        degenerate_fit = '0;
        degenerate_fit.degenerate = 1'b1;

        // The first two rows keep every x at zero, so the fit stays degenerate.
        add_row(16'h0000, 16'h0000, 1'b1, degenerate_fit);
        add_row(16'h0000, 16'hFFFF, 1'b1, degenerate_fit);
        add_row(16'hFFFF, 16'hFFFF, 1'b0, zero_fit);
        add_row(16'hFFFF, 16'h0000, 1'b0, zero_fit);
        add_row(16'h0001, 16'hFFFF, 1'b0, zero_fit);
        add_row(16'h8000, 16'h8000, 1'b0, zero_fit);
        add_row(16'h7FFF, 16'h0001, 1'b0, zero_fit);
        add_row(16'h0001, 16'h0000, 1'b0, zero_fit);
        add_row(16'h0002, 16'hFFFF, 1'b0, zero_fit);
        add_row(16'hAAAA, 16'h5555, 1'b0, zero_fit);
        add_row(16'h5555, 16'hAAAA, 1'b0, zero_fit);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_row(rows[i]);
        // A full window of one x value evicts every older x: degenerate again.
        for (int i = 0; i < Window; i++) begin
            r.x = 16'h1234; r.y = 16'($urandom); r.known = 1'b0;
            send_row(r);
        end

        while (words_sent < RandomWords + rows.size() + Window) begin
            case ($urandom_range(0, 3))
                0: begin
                    base_x = 16'($urandom);
                    repeat ($urandom_range(Window, 2 * Window)) begin
                        r.x = base_x; r.y = 16'($urandom); r.known = 1'b0;
                        send_row(r);
                    end
                end
                1: begin
                    base_x = 16'($urandom);
                    for (int i = 0; i < 40; i++) begin
                        r.x = base_x + 16'(i);
                        r.y = 16'($urandom_range(0, 1)) * 16'hFFFF;
                        r.known = 1'b0;
                        send_row(r);
                    end
                end
                default: begin
                    r.x = 16'($urandom); r.y = 16'($urandom); r.known = 1'b0;
                    send_row(r);
                end
            endcase
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        hold_off = 1'b0;
        wait (words_sent == 20);
        hold_off = 1'b1;
        repeat (3000) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 8) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        fit_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.slope      = m_tdata[47:0];
            got.intercept  = m_tdata[95:48];
            got.degenerate = m_tuser;
            if (fit_queue.size() == 0) begin
                error_count++;
                if (error_count <= MaxShown)
                    $display("Unexpected result word: %h / %b", m_tdata, m_tuser);
            end else begin
                want = fit_queue.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MaxShown)
                        $display("Mismatch: slope %h/%h intercept %h/%h degenerate %b/%b",
                                 want.slope, got.slope, want.intercept, got.intercept,
                                 want.degenerate, got.degenerate);
                end
            end
        end
    end

    initial begin
        error_count = 0;
        words_sent = 0;
        sending_done = 1'b0;
        wait (sending_done);
        wait (fit_queue.size() == 0);
        repeat (500) @(posedge aclk);
        if (error_count == 0 && fit_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
